[sv/iee_pkg.sv]
// Package for the infix expression evaluator: status codes, operator codes,
// character constants, controller types, the command/status and stack
// entry structs and the character decode functions. No dependencies.
package iee_pkg;

  // Status codes reported with each result
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIVZERO = 3'd1;
  localparam logic [2:0] ST_DEEP    = 3'd2;
  localparam logic [2:0] ST_UNBAL   = 3'd3;
  localparam logic [2:0] ST_BADCHAR = 3'd4;

  // Pending operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // ASCII characters of the expression syntax
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_DIGIT, CLS_SPACE, CLS_OP, CLS_OPEN, CLS_CLOSE, CLS_BAD
  } cls_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LATCH, CMD_DIGIT, CMD_LOAD_NUM, CMD_SET_OP, CMD_PUSH,
    CMD_CLOSE, CMD_POP, CMD_ADDSUB, CMD_MUL0, CMD_MUL1, CMD_MUL2,
    CMD_DIV_START, CMD_DIV_DONE, CMD_ERR, CMD_FINISH
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHAR, S_CLOSE_RD, S_TAKE, S_MUL1, S_MUL2,
    S_DIV_WAIT, S_POST, S_LAST_NUM, S_LAST_CHK, S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RET_CHAR, RET_POST, RET_LAST
  } ret_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] err;
  } cmd_t;

  typedef struct packed {
    cls_e       cls;
    logic       in_number;
    logic       err_ok;
    logic       nest_zero;
    logic       nest_full;
    logic       last;
    logic [1:0] opsel;
    logic       opnd_zero;
    logic       div_done;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic [63:0] sum;
    logic [63:0] term;
    logic        neg;
    logic [1:0]  op;
  } stk_t;

  // Sort a character into its syntax class
  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if (c >= CH_ZERO && c <= CH_NINE) r = CLS_DIGIT;
    else if (c == CH_SPACE) r = CLS_SPACE;
    else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) r = CLS_OP;
    else if (c == CH_OPEN) r = CLS_OPEN;
    else if (c == CH_CLOSE) r = CLS_CLOSE;
    else r = CLS_BAD;
    return r;
  endfunction

  // Operator code of an operator character
  function automatic logic [1:0] op_of_char(input logic [7:0] c);
    logic [1:0] r;
    if (c == CH_MINUS) r = OP_SUB;
    else if (c == CH_STAR) r = OP_MUL;
    else if (c == CH_SLASH) r = OP_DIV;
    else r = OP_ADD;
    return r;
  endfunction

endpackage

[sv/iee_div.sv]
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing outside this file.
module iee_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  // Trial subtract of the shifted remainder
  assign rem_sh = {rem_q, quo_q[63]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd64;
      rem_d  = '0;
      quo_d  = dividend_i[63] ? 64'd0 - dividend_i : dividend_i;
      dvs_d  = divisor_i[63] ? 64'd0 - divisor_i : divisor_i;
      neg_d  = dividend_i[63] ^ divisor_i[63];
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'd0 - quo_q : quo_q;

endmodule

[sv/iee_datapath.sv]
// Datapath of the expression evaluator: number accumulator, running sum and
// term, context stack memory, shared multiplier, divider and output register.
// Depends on iee_pkg and iee_div.
module iee_datapath import iee_pkg::*; #(
  parameter int MAX_NESTING = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [7:0]  character_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [2:0]  status_o
);

  localparam int NW = $clog2(MAX_NESTING + 1);
  localparam int IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [7:0]  ch_q;
  logic        last_q;
  logic [63:0] accum_q, accum_d;
  logic        innum_q, innum_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] term_q, term_d;
  logic        neg_q, neg_d;
  logic [1:0]  pend_q, pend_d;
  logic [NW-1:0] nest_q, nest_d;
  logic [2:0]  err_q, err_d;
  logic [63:0] opnd_q, opnd_d;
  logic [1:0]  opsel_q, opsel_d;
  logic [63:0] acc_q, acc_d;
  logic        oval_q, oval_d;
  logic [63:0] oval_value_q;
  logic [2:0]  oval_status_q;
  stk_t        stk_mem [MAX_NESTING];
  stk_t        rd_q;
  logic [NW-1:0] nest_dec;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [63:0] sterm, level_val;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_done;
  logic [63:0] div_quot;

  assign sterm     = neg_q ? 64'd0 - term_q : term_q;
  assign level_val = sum_q + sterm;
  assign nest_dec  = nest_q - NW'(1);
  assign wr_idx    = nest_q[IW-1:0];
  assign rd_idx    = nest_dec[IW-1:0];

  // Shared 32x32 multiplier; partial products of the low 64 bits
  always_comb begin
    mul_a = term_q[31:0];
    mul_b = opnd_q[31:0];
    if (cmd_i.cmd == CMD_MUL1) mul_a = term_q[63:32];
    if (cmd_i.cmd == CMD_MUL2) mul_b = opnd_q[63:32];
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  iee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cmd == CMD_DIV_START),
    .dividend_i (term_q),
    .divisor_i  (opnd_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Next-state of the evaluation registers
  always_comb begin
    accum_d = accum_q;
    innum_d = innum_q;
    sum_d   = sum_q;
    term_d  = term_q;
    neg_d   = neg_q;
    pend_d  = pend_q;
    nest_d  = nest_q;
    err_d   = err_q;
    opnd_d  = opnd_q;
    opsel_d = opsel_q;
    acc_d   = acc_q;
    unique case (cmd_i.cmd)
      CMD_DIGIT: begin
        accum_d = (accum_q << 3) + (accum_q << 1) + {60'd0, ch_q[3:0]};
        innum_d = 1'b1;
      end
      CMD_LOAD_NUM: begin
        opnd_d  = accum_q;
        opsel_d = pend_q;
        innum_d = 1'b0;
        accum_d = '0;
      end
      CMD_SET_OP: pend_d = op_of_char(ch_q);
      CMD_PUSH: begin
        nest_d = nest_q + NW'(1);
        sum_d  = '0;
        term_d = '0;
        neg_d  = 1'b0;
        pend_d = OP_ADD;
      end
      CMD_CLOSE: begin
        opnd_d = level_val;
        nest_d = nest_dec;
      end
      CMD_POP: begin
        sum_d   = rd_q.sum;
        term_d  = rd_q.term;
        neg_d   = rd_q.neg;
        opsel_d = rd_q.op;
      end
      CMD_ADDSUB: begin
        sum_d  = level_val;
        term_d = opnd_q;
        neg_d  = (opsel_q == OP_SUB);
      end
      CMD_MUL0: acc_d = prod;
      CMD_MUL1: acc_d = acc_q + {prod[31:0], 32'd0};
      CMD_MUL2: term_d = acc_q + {prod[31:0], 32'd0};
      CMD_DIV_DONE: term_d = div_quot;
      CMD_ERR: begin
        if (err_q == ST_OK) err_d = cmd_i.err;
      end
      CMD_FINISH: begin
        accum_d = '0;
        innum_d = 1'b0;
        sum_d   = '0;
        term_d  = '0;
        neg_d   = 1'b0;
        pend_d  = OP_ADD;
        nest_d  = '0;
        err_d   = ST_OK;
      end
      default: ;
    endcase
  end

  // Hold the result word until the receiver takes it
  always_comb begin
    oval_d = oval_q;
    if (out_ready_i) oval_d = 1'b0;
    if (cmd_i.cmd == CMD_FINISH) oval_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      innum_q <= 1'b0;
      sum_q   <= '0;
      term_q  <= '0;
      neg_q   <= 1'b0;
      pend_q  <= OP_ADD;
      nest_q  <= '0;
      err_q   <= ST_OK;
      oval_q  <= 1'b0;
    end else begin
      accum_q <= accum_d;
      innum_q <= innum_d;
      sum_q   <= sum_d;
      term_q  <= term_d;
      neg_q   <= neg_d;
      pend_q  <= pend_d;
      nest_q  <= nest_d;
      err_q   <= err_d;
      oval_q  <= oval_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    opnd_q  <= opnd_d;
    opsel_q <= opsel_d;
    acc_q   <= acc_d;
    if (cmd_i.cmd == CMD_LATCH) begin
      ch_q   <= character_i;
      last_q <= last_char_i;
    end
    if (cmd_i.cmd == CMD_FINISH) begin
      oval_value_q  <= (err_q == ST_OK) ? level_val : 64'd0;
      oval_status_q <= err_q;
    end
  end

  // Context stack: push writes the current level, close reads the one below
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_PUSH) begin
      stk_mem[wr_idx] <= '{sum: sum_q, term: term_q, neg: neg_q, op: pend_q};
    end
    if (cmd_i.cmd == CMD_CLOSE) begin
      rd_q <= stk_mem[rd_idx];
    end
  end

  assign stat_o = '{
    cls:       classify(ch_q),
    in_number: innum_q,
    err_ok:    (err_q == ST_OK),
    nest_zero: (nest_q == '0),
    nest_full: (nest_q >= NW'(MAX_NESTING)),
    last:      last_q,
    opsel:     opsel_q,
    opnd_zero: (opnd_q == 64'd0),
    div_done:  div_done,
    out_free:  (!oval_q || out_ready_i)
  };

  assign out_valid_o = oval_q;
  assign value_o     = oval_value_q;
  assign status_o    = oval_status_q;

  a_nest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q <= NW'(MAX_NESTING)) else $error("nesting count beyond stack depth");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_FINISH |=> err_q == ST_OK && nest_q == '0 && !innum_q)
    else $error("state not cleared after result");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_DIV_START |-> opnd_q != 64'd0)
    else $error("divider started with zero divisor");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_CLOSE |-> nest_q != '0)
    else $error("pop from empty context stack");

endmodule

[sv/iee_ctrl.sv]
// Controller state machine of the expression evaluator: sequences each
// character through the datapath by command. Depends on iee_pkg.
module iee_ctrl import iee_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  state_e ret_state;

  // Where an operand fold returns to
  always_comb begin
    unique case (ret_q)
      RET_CHAR: ret_state = S_CHAR;
      RET_POST: ret_state = S_POST;
      RET_LAST: ret_state = S_LAST_CHK;
      default:  ret_state = S_POST;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (!stat_i.err_ok || stat_i.cls == CLS_DIGIT) begin
          state_d = S_POST;
        end else if (stat_i.in_number) begin
          state_d = S_TAKE;
          ret_d   = RET_CHAR;
        end else begin
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (stat_i.err_ok && stat_i.cls == CLS_CLOSE && !stat_i.nest_zero) begin
          state_d = S_CLOSE_RD;
        end else begin
          state_d = S_POST;
        end
      end
      S_CLOSE_RD: begin
        state_d = S_TAKE;
        ret_d   = RET_POST;
      end
      S_TAKE: begin
        unique case (stat_i.opsel)
          OP_MUL:  state_d = S_MUL1;
          OP_DIV:  state_d = stat_i.opnd_zero ? ret_state : S_DIV_WAIT;
          default: state_d = ret_state;
        endcase
      end
      S_MUL1:     state_d = S_MUL2;
      S_MUL2:     state_d = ret_state;
      S_DIV_WAIT: if (stat_i.div_done) state_d = ret_state;
      S_POST:     state_d = stat_i.last ? S_LAST_NUM : S_IDLE;
      S_LAST_NUM: begin
        if (stat_i.err_ok && stat_i.in_number) begin
          state_d = S_TAKE;
          ret_d   = RET_LAST;
        end else begin
          state_d = S_LAST_CHK;
        end
      end
      S_LAST_CHK: state_d = S_FINISH;
      S_FINISH:   if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '{cmd: CMD_NONE, err: ST_OK};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.cmd = CMD_LATCH;
      end
      S_DISPATCH: begin
        if (stat_i.err_ok) begin
          if (stat_i.cls == CLS_DIGIT) cmd_o.cmd = CMD_DIGIT;
          else if (stat_i.in_number) cmd_o.cmd = CMD_LOAD_NUM;
        end
      end
      S_CHAR: begin
        if (stat_i.err_ok) begin
          unique case (stat_i.cls)
            CLS_OP: cmd_o.cmd = CMD_SET_OP;
            CLS_OPEN: begin
              if (stat_i.nest_full) cmd_o = '{cmd: CMD_ERR, err: ST_DEEP};
              else cmd_o.cmd = CMD_PUSH;
            end
            CLS_CLOSE: begin
              if (stat_i.nest_zero) cmd_o = '{cmd: CMD_ERR, err: ST_UNBAL};
              else cmd_o.cmd = CMD_CLOSE;
            end
            CLS_BAD: cmd_o = '{cmd: CMD_ERR, err: ST_BADCHAR};
            default: ;
          endcase
        end
      end
      S_CLOSE_RD: cmd_o.cmd = CMD_POP;
      S_TAKE: begin
        unique case (stat_i.opsel)
          OP_MUL: cmd_o.cmd = CMD_MUL0;
          OP_DIV: begin
            if (stat_i.opnd_zero) cmd_o = '{cmd: CMD_ERR, err: ST_DIVZERO};
            else cmd_o.cmd = CMD_DIV_START;
          end
          default: cmd_o.cmd = CMD_ADDSUB;
        endcase
      end
      S_MUL1:     cmd_o.cmd = CMD_MUL1;
      S_MUL2:     cmd_o.cmd = CMD_MUL2;
      S_DIV_WAIT: if (stat_i.div_done) cmd_o.cmd = CMD_DIV_DONE;
      S_LAST_NUM: if (stat_i.err_ok && stat_i.in_number) cmd_o.cmd = CMD_LOAD_NUM;
      S_LAST_CHK: begin
        if (stat_i.err_ok && !stat_i.nest_zero) cmd_o = '{cmd: CMD_ERR, err: ST_UNBAL};
      end
      S_FINISH: if (stat_i.out_free) cmd_o.cmd = CMD_FINISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_POST;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

[sv/infix_expression_evaluator_core.sv]
// Infix expression evaluator, top level.
// Input channel: one ASCII character per word (character_i, last_char_i) on
// in_valid_i/in_ready_o. Digits, + - * /, parentheses and spaces are legal.
// Output channel: one word per expression on out_valid_o/out_ready_i, given
// after the character flagged last: value_o (64-bit two's complement, wraps)
// and status_o (ok, divide by zero, too deep, unbalanced, invalid character).
// Steps per character: latch, dispatch, the character state for any but a
// digit, then post. Ending a number adds a fold: an add step for + or -,
// the partial-product steps for *, and for / the serial divider (one
// quotient bit per cycle). A close parenthesis can fold two operands
// through the divider. The last character adds the last-number, check and
// finish steps plus any final fold before the result word is loaded.
// One character is in work at a time; in_ready_o is high only between them.
// The result sits in an output register, so the next expression's characters
// are taken while a result waits; the block stalls only if a second result
// is ready before the first is taken.
// Reset clears all evaluation state; the context stack needs no clearing.
module infix_expression_evaluator_core import iee_pkg::*; #(
  parameter int MAX_NESTING = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         character_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] value_o,
  output logic [2:0]         status_o
);

  cmd_t        cmd;
  stat_t       stat;
  logic [63:0] value;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iee_datapath #(
    .MAX_NESTING (MAX_NESTING)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value),
    .status_o    (status_o)
  );

  assign value_o = signed'(value);

endmodule

[tb/infix_expression_evaluator_core_tb.sv]
// Testbench for infix_expression_evaluator_core: drives expressions one
// character per word and checks each result word against a running evaluator.
// Depends on iee_pkg and the core.
`timescale 1ns / 100ps

module infix_expression_evaluator_core_tb;
  import iee_pkg::*;

  localparam int DEPTH = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] character_i = 8'h00;
  logic last_char_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] value_o;
  logic [2:0] status_o;

  infix_expression_evaluator_core #(.MAX_NESTING(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .character_i(character_i), .last_char_i(last_char_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .value_o(value_o), .status_o(status_o)
  );

  always #2ns clk_i = ~clk_i;

  // Evaluator state
  logic [63:0] acc, sum, term;
  logic        in_num, neg;
  logic [1:0]  op;
  int          level;
  logic [2:0]  err;
  logic [63:0] stk_sum [DEPTH];
  logic [63:0] stk_term [DEPTH];
  logic        stk_neg [DEPTH];
  logic [1:0]  stk_op [DEPTH];

  char_word_t  char_queue[$];
  result_t     expected_results[$];
  int          mismatches = 0;
  int          send_idle_pct = 21;
  int          recv_idle_pct = 68;
  bit          recv_hold = 1'b0;
  bit          hold_send = 1'b0;
  longint      cycles = 0;

  function automatic logic [63:0] term_value();
    return neg ? 64'd0 - term : term;
  endfunction

  function automatic logic [63:0] quotient(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? 64'd0 - q : q;
  endfunction

  task automatic clear_state();
    acc = '0; in_num = 1'b0; sum = '0; term = '0; neg = 1'b0;
    op = OP_ADD; level = 0; err = ST_OK;
  endtask

  task automatic fold_operand(input logic [63:0] v, input logic [1:0] o);
    case (o)
      OP_ADD, OP_SUB: begin
        sum = sum + term_value();
        term = v;
        neg = (o == OP_SUB);
      end
      OP_MUL: term = term * v;
      default: begin
        if (v == 0) begin
          if (err == ST_OK) err = ST_DIVZERO;
        end else begin
          term = quotient(term, v);
        end
      end
    endcase
  endtask

  task automatic finish_number();
    if (in_num) begin
      fold_operand(acc, op);
      in_num = 1'b0;
      acc = '0;
    end
  endtask

  task automatic eval_char(input logic [7:0] c);
    logic [63:0] v;
    logic [1:0]  inner;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      acc = acc * 10 + 64'(c - CH_ZERO);
      in_num = 1'b1;
      return;
    end
    finish_number();
    if (err != ST_OK) return;
    case (c)
      CH_SPACE: ;
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_OPEN: begin
        if (level >= DEPTH) begin
          err = ST_DEEP;
        end else begin
          stk_sum[level] = sum; stk_term[level] = term;
          stk_neg[level] = neg; stk_op[level] = op;
          level++;
          sum = '0; term = '0; neg = 1'b0; op = OP_ADD;
        end
      end
      CH_CLOSE: begin
        inner = op;
        if (level == 0) begin
          err = ST_UNBAL;
        end else begin
          v = sum + term_value();
          level--;
          sum = stk_sum[level]; term = stk_term[level]; neg = stk_neg[level];
          fold_operand(v, stk_op[level]);
          op = inner;
        end
      end
      default: err = ST_BADCHAR;
    endcase
  endtask

  // Predict the result word, if any, of one accepted character word
  task automatic predict_char(input char_word_t w);
    result_t r;
    if (err == ST_OK) eval_char(w.ch);
    if (!w.last) return;
    if (err == ST_OK) finish_number();
    if (err == ST_OK && level != 0) err = ST_UNBAL;
    r.value = (err == ST_OK) ? sum + term_value() : 64'd0;
    r.status = err;
    expected_results = {expected_results, r};
    clear_state();
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: hold valid and payload until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_char('{character_i, last_char_i});
      if ((!in_valid_i || in_ready_o) && char_queue.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        char_word_t w;
        w = char_queue.pop_front();
        in_valid_i <= 1'b1;
        character_i <= w.ch;
        last_char_i <= w.last;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result word, then choose next ready
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("infix_expression_evaluator_core_tb failed");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word");
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (value_o !== e.value)
            report_mismatch($sformatf("value %0d, want %0d", value_o, $signed(e.value)));
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
        end
      end
      if (recv_hold) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic char_word_t cw(input logic [7:0] c, input logic l = 1'b0);
    return '{c, l};
  endfunction

  // Append one word to the pending queue
  task automatic enqueue_word(input char_word_t w);
    char_queue = {char_queue, w};
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      enqueue_word(cw(s[i], i == s.len() - 1));
  endtask

  task automatic queue_number(input int digits);
    for (int i = 0; i < digits; i++)
      enqueue_word(cw(8'(CH_ZERO + $urandom_range(9))));
  endtask

  function automatic logic [7:0] random_op();
    case ($urandom_range(3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Random well-formed expression, sometimes broken or noisy
  task automatic queue_expression();
    int n, depth;
    logic [7:0] c;
    n = $urandom_range(1, 6);
    depth = 0;
    for (int t = 0; t < n; t++) begin
      if (t > 0) enqueue_word(cw(random_op()));
      if ($urandom_range(9) == 0) enqueue_word(cw(CH_SPACE));
      if (depth < 18 && $urandom_range(3) == 0) begin
        enqueue_word(cw(CH_OPEN));
        depth++;
      end
      queue_number($urandom_range(3) == 0 ? $urandom_range(1, 20) : $urandom_range(1, 3));
      if (depth > 0 && $urandom_range(2) == 0) begin
        enqueue_word(cw(CH_CLOSE));
        depth--;
      end
    end
    while (depth > 0 && $urandom_range(9) != 0) begin
      enqueue_word(cw(CH_CLOSE));
      depth--;
    end
    if ($urandom_range(14) == 0) enqueue_word(cw(8'($urandom_range(255))));
    if ($urandom_range(19) == 0) enqueue_word(cw(CH_CLOSE));
    c = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CH_SPACE;
    enqueue_word(cw(c, 1'b1));
  endtask

  task automatic wait_drained();
    while (char_queue.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    string deep;
    clear_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cases
    queue_text("1+2*3");
    queue_text("20/3-7/-2");
    queue_text("7 / 0");
    queue_text("*5+1");
    queue_text("()");
    queue_text(" ");
    queue_text("2(3)");
    queue_text("4-(1+2)*3");
    queue_text("(8-2*)5");
    queue_text("1)+2");
    queue_text("(1+2");
    queue_text("3#4+(");
    queue_text("18446744073709551615*99999999999999999999");
    queue_text("0-9223372036854775807-1");
    queue_text("(0-9223372036854775807-1)/(0-1)");
    deep = "";
    for (int i = 0; i < 16; i++) deep = {deep, "("};
    deep = {deep, "1"};
    for (int i = 0; i < 16; i++) deep = {deep, ")"};
    queue_text(deep);
    queue_text({"(", deep});
    enqueue_word(cw(8'hFF, 1'b1));
    enqueue_word(cw(8'h00, 1'b1));

    // Random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      while (char_queue.size() < 470 * (ph + 1) - 470 * ph + char_queue.size() * 0 &&
             char_queue.size() < 470)
        queue_expression();
      if (ph == 0) begin
        // long receiver hold-off while words keep coming
        fork
          begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      wait_drained();
      // sender pauses once every result is in
      hold_send = 1'b1;
      repeat (200) @(posedge clk_i);
      hold_send = 1'b0;
      send_idle_pct = (ph == 0) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 21 : 0;
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("infix_expression_evaluator_core_tb passed");
    end else begin
      $display("infix_expression_evaluator_core_tb failed");
    end
    $finish;
  end

endmodule
